>>> design/bfnp_pkg.sv
`default_nettype none

package bfnp_pkg;

   // request operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // response status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_FOUND = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // fixed field widths
   localparam int DIM_REG_W = 5;
   localparam int OUT_IDX_W = 10;

   // control that travels with one scanned coordinate
   typedef struct packed {
      logic valid;
      logic last;
      logic first;
   } tag_type;

endpackage

`default_nettype wire

>>> design/bfnp_cell.sv
`default_nettype none

module bfnp_cell #(
   parameter int WIDTH = 16
) (
   input  wire logic                    clock,
   input  wire logic                    shift_en,
   input  wire logic                    take_tail,
   input  wire logic signed [WIDTH-1:0] next_q,
   input  wire logic signed [WIDTH-1:0] tail_q,
   output logic signed [WIDTH-1:0]      q
);

   logic signed [WIDTH-1:0] q_ff;
   logic signed [WIDTH-1:0] q_in;

   // the last active cell takes the wrapped or loaded value
   assign q_in = take_tail ? tail_q : next_q;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

>>> design/bfnp_chain.sv
`default_nettype none

module bfnp_chain #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int KW    = 4
) (
   input  wire logic                    clock,
   input  wire logic                    shift_en,
   input  wire logic                    load,
   input  wire logic signed [WIDTH-1:0] load_q,
   input  wire logic [KW-1:0]           last_sel,
   output logic signed [WIDTH-1:0]      head_q
);

   logic signed [WIDTH-1:0] cq [DEPTH];
   logic signed [WIDTH-1:0] tail_q;

   // new query coordinates enter at the tail, otherwise the head wraps around
   assign tail_q = load ? load_q : cq[0];
   assign head_q = cq[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_end
         bfnp_cell #(.WIDTH(WIDTH)) u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .take_tail (1'b1),
            .next_q    (tail_q),
            .tail_q    (tail_q),
            .q         (cq[i])
         );
      end else begin : g_mid
         bfnp_cell #(.WIDTH(WIDTH)) u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .take_tail (last_sel == KW'(i)),
            .next_q    (cq[i+1]),
            .tail_q    (tail_q),
            .q         (cq[i])
         );
      end
   end

endmodule

`default_nettype wire

>>> design/bfnp_mac.sv
`default_nettype none

module bfnp_mac #(
   parameter int CW       = 16,
   parameter int IW       = 10,
   parameter int MAX_DIMS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bfnp_pkg::tag_type    tag,
   input  wire logic [IW-1:0]        idx,
   input  wire logic signed [CW-1:0] qry_q,
   input  wire logic signed [CW-1:0] rd_q,
   output logic                      busy,
   output logic [IW-1:0]             best_idx
);

   import bfnp_pkg::*;

   localparam int AW = CW + 1;
   localparam int QW = 2 * CW + 2;
   localparam int SW = QW + $clog2(MAX_DIMS + 1);

   tag_type              s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [IW-1:0]        s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic signed [CW-1:0] s1_q_ff;
   logic [AW-1:0]        s2_abs_ff;
   logic [QW-1:0]        s3_sq_ff;
   logic [SW-1:0]        acc_ff, best_ff;
   logic [IW-1:0]        best_idx_ff;

   logic signed [AW-1:0] diff;
   logic [AW-1:0]        abs_in;
   logic [QW-1:0]        sq_in;
   logic [SW-1:0]        sum;

   // absolute difference of stored and query coordinate
   assign diff   = {rd_q[CW-1], rd_q} - {s1_q_ff[CW-1], s1_q_ff};
   assign abs_in = diff[AW-1] ? AW'(-diff) : AW'(diff);

   // square of the difference
   assign sq_in = s2_abs_ff * s2_abs_ff;

   // running distance of the current point
   assign sum = acc_ff + SW'(s3_sq_ff);

   // tag pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // data pipeline
   always_ff @(posedge clock) begin
      s1_q_ff   <= qry_q;
      s1_idx_ff <= idx;
      s2_abs_ff <= abs_in;
      s2_idx_ff <= s1_idx_ff;
      s3_sq_ff  <= sq_in;
      s3_idx_ff <= s2_idx_ff;
   end

   // accumulate and keep the first strictly smallest distance
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s3_tag_ff.valid) begin
         acc_ff <= s3_tag_ff.last ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_tag_ff.valid && s3_tag_ff.last && (s3_tag_ff.first || sum < best_ff)) begin
         best_ff     <= sum;
         best_idx_ff <= s3_idx_ff;
      end
   end

   assign busy     = s1_tag_ff.valid | s2_tag_ff.valid | s3_tag_ff.valid;
   assign best_idx = best_idx_ff;

endmodule

`default_nettype wire

>>> design/brute_force_nearest_point.sv
`default_nettype none

// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_op, req_coord
// rsp_      out        rsp_valid / rsp_stall  rsp_status, rsp_nearest_index
// csr_      in         csr_we                 csr_wdata (dimensions)
//
// the last query coordinate starts a scan over all stored points and active
// dimensions, one stored coordinate per cycle, and the read register and the distance pipeline then load the response
// reset clears the point count and coordinate counters, not the point memory
// every request stalls during a scan, and one that would give a response also
// stalls while the response register is full and stalled
// a query scan waits at its end for a free response register

module brute_force_nearest_point #(
   parameter int MAX_POINTS  = 1024,
   parameter int MAX_DIMS    = 16,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_op,
   input  wire logic signed [COORD_WIDTH-1:0]       req_coord,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output bfnp_pkg::status_type                     rsp_status,
   output logic [bfnp_pkg::OUT_IDX_W-1:0]           rsp_nearest_index,
   input  wire logic                                csr_we,
   input  wire logic [bfnp_pkg::DIM_REG_W-1:0]      csr_wdata
);

   import bfnp_pkg::*;

   localparam int KW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNTW    = $clog2(MAX_POINTS + 1);
   localparam int IW      = $clog2(MAX_POINTS);
   localparam int DEPTH   = MAX_POINTS * MAX_DIMS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW      = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;
   localparam int RST_DM1 = (MAX_DIMS >= 2) ? 1 : 0;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;

   logic [1:0]               state_ff;
   logic [KW-1:0]            dm1_ff, dm1_in;
   logic [CNTW-1:0]          count_ff;
   logic [KW-1:0]            add_k_ff, qry_k_ff, scan_k_ff;
   logic [AW-1:0]            add_addr_ff, scan_addr_ff;
   logic [IW-1:0]            scan_pt_ff;
   logic signed [COORD_WIDTH-1:0] rd_q_ff;
   logic signed [COORD_WIDTH-1:0] mem [DEPTH];

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [OUT_IDX_W-1:0]     rsp_index_ff;

   logic full, no_points, add_last, qry_last, makes_rsp, slot_free;
   logic req_accept, is_add, is_qry, scan_issue, scan_k_last, scan_pt_last;
   logic mac_busy, done_take;
   logic signed [COORD_WIDTH-1:0] head_q;
   logic [IW-1:0]            best_idx;
   logic [XW-1:0]            best_ext;
   tag_type                  issue_tag;

   // request decode
   assign full      = count_ff == CNTW'(MAX_POINTS);
   assign no_points = count_ff == '0;
   assign add_last  = add_k_ff == dm1_ff;
   assign qry_last  = qry_k_ff == dm1_ff;
   assign makes_rsp = (req_op == OP_ADD) ? (add_last && full) : (qry_last && no_points);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || (!slot_free && makes_rsp);
   assign req_accept = req_valid && !req_stall;
   assign is_add    = req_accept && (req_op == OP_ADD);
   assign is_qry    = req_accept && (req_op == OP_QUERY);

   // scan sequencing
   assign scan_issue   = state_ff == S_SCAN;
   assign scan_k_last  = scan_k_ff == dm1_ff;
   assign scan_pt_last = CNTW'(scan_pt_ff) == count_ff - CNTW'(1);
   assign done_take    = (state_ff == S_WAIT) && !mac_busy && slot_free;

   // dimension register clamped to the supported range
   always_comb begin
      if (csr_wdata == '0) begin
         dm1_in = '0;
      end else if (int'(csr_wdata) > MAX_DIMS) begin
         dm1_in = KW'(MAX_DIMS - 1);
      end else begin
         dm1_in = KW'(csr_wdata - DIM_REG_W'(1));
      end
   end

   // counters, store fill and scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dm1_ff       <= KW'(RST_DM1);
         count_ff     <= '0;
         add_k_ff     <= '0;
         qry_k_ff     <= '0;
         add_addr_ff  <= '0;
         scan_addr_ff <= '0;
         scan_k_ff    <= '0;
         scan_pt_ff   <= '0;
      end else if (csr_we) begin
         dm1_ff      <= dm1_in;
         count_ff    <= '0;
         add_k_ff    <= '0;
         qry_k_ff    <= '0;
         add_addr_ff <= '0;
      end else begin
         if (is_add) begin
            add_k_ff <= add_last ? '0 : add_k_ff + KW'(1);
            if (!full) begin
               add_addr_ff <= add_addr_ff + AW'(1);
               if (add_last) begin
                  count_ff <= count_ff + CNTW'(1);
               end
            end
         end
         if (is_qry) begin
            qry_k_ff <= qry_last ? '0 : qry_k_ff + KW'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (is_qry && qry_last && !no_points) begin
                  state_ff     <= S_SCAN;
                  scan_addr_ff <= '0;
                  scan_k_ff    <= '0;
                  scan_pt_ff   <= '0;
               end
            end
            S_SCAN: begin
               scan_addr_ff <= scan_addr_ff + AW'(1);
               if (scan_k_last) begin
                  scan_k_ff  <= '0;
                  scan_pt_ff <= scan_pt_ff + IW'(1);
                  if (scan_pt_last) begin
                     state_ff <= S_WAIT;
                  end
               end else begin
                  scan_k_ff <= scan_k_ff + KW'(1);
               end
            end
            S_WAIT: begin
               if (done_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // point memory, packed at the active dimension count
   always_ff @(posedge clock) begin
      if (is_add && !full) begin
         mem[add_addr_ff] <= req_coord;
      end
      rd_q_ff <= mem[scan_addr_ff];
   end

   // query coordinates held in a rotating chain of cells
   bfnp_chain #(
      .DEPTH (MAX_DIMS),
      .WIDTH (COORD_WIDTH),
      .KW    (KW)
   ) u_chain (
      .clock    (clock),
      .shift_en (is_qry | scan_issue),
      .load     (is_qry),
      .load_q   (req_coord),
      .last_sel (dm1_ff),
      .head_q   (head_q)
   );

   // distance pipeline
   assign issue_tag.valid = scan_issue;
   assign issue_tag.last  = scan_k_last;
   assign issue_tag.first = scan_pt_ff == '0;

   bfnp_mac #(
      .CW       (COORD_WIDTH),
      .IW       (IW),
      .MAX_DIMS (MAX_DIMS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .tag      (issue_tag),
      .idx      (scan_pt_ff),
      .qry_q    (head_q),
      .rd_q     (rd_q_ff),
      .busy     (mac_busy),
      .best_idx (best_idx)
   );

   assign best_ext = XW'(best_idx);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((req_accept && makes_rsp) || done_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && makes_rsp) begin
         rsp_status_ff <= (req_op == OP_ADD) ? ST_FULL : ST_EMPTY;
         rsp_index_ff  <= '0;
      end else if (done_take) begin
         rsp_status_ff <= ST_FOUND;
         rsp_index_ff  <= best_ext[OUT_IDX_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_nearest_index = rsp_index_ff;

   // no request taken while a scan is running
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_accept)
      else $error("request accepted during scan");

   // the scan never walks past the stored points
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CNTW'(scan_pt_ff) < count_ff))
      else $error("scan index beyond point count");

   // distance pipeline only runs during a scan
   a_mac_in_scan: assert property (@(posedge clock) disable iff (reset)
      mac_busy |-> (state_ff != S_IDLE))
      else $error("distance pipeline active while idle");

   // end of scan loads a found response
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      done_take |=> (rsp_valid_ff && rsp_status_ff == ST_FOUND))
      else $error("scan ended without response");

endmodule

`default_nettype wire

>>> bench/nearest_point_checker.sv
`timescale 1ns / 100ps

module nearest_point_checker #(
   parameter int MAX_POINTS  = 1024,
   parameter int MAX_DIMS    = 16,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_op,
   input  wire logic signed [COORD_WIDTH-1:0]       req_coord,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire bfnp_pkg::status_type                rsp_status,
   input  wire logic [bfnp_pkg::OUT_IDX_W-1:0]      rsp_nearest_index,
   input  wire logic                                csr_we,
   input  wire logic [bfnp_pkg::DIM_REG_W-1:0]      csr_wdata,
   output int                                       failures,
   output int                                       outstanding,
   output int                                       responses_seen
);

   import bfnp_pkg::*;

   localparam int DIMS_AT_RESET = 2;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      status_type             status;
      logic [OUT_IDX_W-1:0]   index;
   } answer_type;

   // shadow copy of the point memory and the query being assembled
   logic signed [COORD_WIDTH-1:0] point_mem [MAX_POINTS][MAX_DIMS];
   logic signed [COORD_WIDTH-1:0] query_mem [MAX_DIMS];
   int unsigned point_total, add_slot, query_slot, active_dims;

   answer_type answers_due [$];
   int fail_count = 0;
   int seen_count = 0;

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type due;
      answer_type got;
      logic store_full;
      longint unsigned dist_sum, best_sum;
      longint diff;
      int unsigned best_i;

      if (reset) begin
         active_dims = DIMS_AT_RESET;
         point_total = 0;
         add_slot = 0;
         query_slot = 0;
         answers_due.delete();
      end else begin
         // compare an accepted response with the oldest answer due
         if (rsp_valid && !rsp_stall) begin
            seen_count++;
            got.status = rsp_status;
            got.index = rsp_nearest_index;
            if (answers_due.size() == 0) begin
               note_failure($sformatf("response with nothing expected: status %0d index %0d",
                                      got.status, got.index));
            end else begin
               due = answers_due.pop_front();
               if (got.status !== due.status) begin
                  note_failure($sformatf("status mismatch: expected %0d got %0d",
                                         due.status, got.status));
               end
               if (got.index !== due.index) begin
                  note_failure($sformatf("nearest index mismatch: expected %0d got %0d",
                                         due.index, got.index));
               end
            end
         end

         // dimension write clears the store and both counters
         if (csr_we) begin
            if (csr_wdata == 0) begin
               active_dims = 1;
            end else if (csr_wdata > MAX_DIMS) begin
               active_dims = MAX_DIMS;
            end else begin
               active_dims = csr_wdata;
            end
            point_total = 0;
            add_slot = 0;
            query_slot = 0;
         end

         // accepted request
         if (req_valid && !req_stall) begin
            if (req_op == OP_ADD) begin
               store_full = (point_total >= MAX_POINTS);
               if (!store_full) begin
                  point_mem[point_total][add_slot] = req_coord;
               end
               add_slot++;
               if (add_slot >= active_dims) begin
                  add_slot = 0;
                  if (!store_full) begin
                     point_total++;
                  end else begin
                     due.status = ST_FULL;
                     due.index = '0;
                     answers_due.push_back(due);
                  end
               end
            end else begin
               query_mem[query_slot] = req_coord;
               query_slot++;
               if (query_slot >= active_dims) begin
                  query_slot = 0;
                  if (point_total == 0) begin
                     due.status = ST_EMPTY;
                     due.index = '0;
                  end else begin
                     // exact squared distance, first point wins on ties
                     best_sum = 0;
                     best_i = 0;
                     for (int unsigned i = 0; i < point_total; i++) begin
                        dist_sum = 0;
                        for (int unsigned k = 0; k < active_dims; k++) begin
                           diff = longint'(point_mem[i][k]) - longint'(query_mem[k]);
                           dist_sum += diff * diff;
                        end
                        if (i == 0 || dist_sum < best_sum) begin
                           best_sum = dist_sum;
                           best_i = i;
                        end
                     end
                     due.status = ST_FOUND;
                     due.index = best_i[OUT_IDX_W-1:0];
                  end
                  answers_due.push_back(due);
               end
            end
         end
      end

      failures <= fail_count;
      outstanding <= answers_due.size();
      responses_seen <= seen_count;
   end

endmodule

>>> bench/brute_force_nearest_point_test.sv
`timescale 1ns / 100ps

module brute_force_nearest_point_test;

   import bfnp_pkg::*;

   localparam int POINT_CAPACITY = 1024;
   localparam int DIM_LIMIT      = 16;
   localparam int COORD_W        = 16;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 56;
   localparam int PLAN_LEN       = 9;

   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_op;
   logic signed [COORD_W-1:0]     req_coord;
   logic                          rsp_valid;
   logic                          rsp_stall;
   status_type                    rsp_status;
   logic [OUT_IDX_W-1:0]          rsp_nearest_index;
   logic                          csr_we;
   logic [DIM_REG_W-1:0]          csr_wdata;

   int failures, outstanding, responses_seen;

   int unsigned sent = 0;
   int unsigned settings = 0;
   int unsigned cur_dims = 2;
   bit sender_eager = 1'b0;
   bit hold_request = 1'b0;
   logic [DIM_REG_W-1:0] dims_plan [PLAN_LEN];

   brute_force_nearest_point #(
      .MAX_POINTS  (POINT_CAPACITY),
      .MAX_DIMS    (DIM_LIMIT),
      .COORD_WIDTH (COORD_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_coord         (req_coord),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_nearest_index (rsp_nearest_index),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   nearest_point_checker #(
      .MAX_POINTS  (POINT_CAPACITY),
      .MAX_DIMS    (DIM_LIMIT),
      .COORD_WIDTH (COORD_W)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_coord         (req_coord),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_nearest_index (rsp_nearest_index),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .failures          (failures),
      .outstanding       (outstanding),
      .responses_seen    (responses_seen)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // coordinates biased toward the extremes and a small cluster that makes ties
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2, 3: return COORD_W'($urandom_range(0, 8) - 4);
         default: return COORD_W'($urandom());
      endcase
   endfunction

   // offer one request after a random gap and wait for it to be taken
   task automatic send_request(input logic op, input logic signed [COORD_W-1:0] coord);
      int unsigned gap;
      if ($urandom_range(0, 23) == 0) begin
         sender_eager = !sender_eager;
      end
      gap = sender_eager ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= op;
      req_coord <= coord;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // stop sending and wait until every response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // dimension write, only while the block is idle
   task automatic write_dims(input logic [DIM_REG_W-1:0] value);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (value == 0) begin
         cur_dims = 1;
      end else if (value > DIM_LIMIT) begin
         cur_dims = DIM_LIMIT;
      end else begin
         cur_dims = value;
      end
      settings++;
   endtask

   task automatic add_point();
      repeat (cur_dims) send_request(OP_ADD, random_coord());
   endtask

   task automatic run_query();
      repeat (cur_dims) send_request(OP_QUERY, random_coord());
   endtask

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin : receiver
      int unsigned gap;
      bit eager;
      eager = 1'b0;
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if ($urandom_range(0, 23) == 0) begin
               eager = !eager;
            end
            gap = eager ? 0 : $urandom_range(0, 8);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid && !hold_request);
      end
   end

   // request stimulus
   initial begin : stimulus
      int unsigned phase_end;

      dims_plan = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd5, 5'd17, 5'd8, 5'd2};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= OP_ADD;
      req_coord <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, corner points, ties and duplicates at two dimensions
      send_request(OP_QUERY, COORD_MIN);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_ADD, COORD_MIN);
      send_request(OP_ADD, COORD_MIN);
      send_request(OP_ADD, COORD_MAX);
      send_request(OP_ADD, COORD_MAX);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_QUERY, COORD_MIN);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_ADD, COORD_MAX);
      send_request(OP_ADD, COORD_MAX);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_QUERY, COORD_MAX);
      send_request(OP_QUERY, '0);
      send_request(OP_QUERY, '0);
      drain();

      // back-pressure: responses held off while queries keep coming
      write_dims(5'd1);
      repeat (4) add_point();
      drain();
      hold_request = 1'b1;
      repeat (14) run_query();
      drain();

      // random phases over several dimension settings
      for (int p = 0; p < PLAN_LEN; p++) begin
         write_dims(dims_plan[p]);
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: add_point();
               11, 12, 13, 14, 15, 16: run_query();
               default: send_request($urandom_range(0, 1) ? OP_QUERY : OP_ADD, random_coord());
            endcase
            if ($urandom_range(0, 40) == 0) begin
               drain();
            end
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests across %0d dimension settings, %0d responses compared",
               sent, settings, responses_seen);
      $display("including empty-store queries, tied distances, clamped dimensions "
               , "and a long hold-off");
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
